### src/bmv_pkg.sv
`default_nettype none
package bmv_pkg;

	typedef enum logic [2:0] {
		CMD_MEM_READ   = 3'd0,
		CMD_MEM_WRITE  = 3'd1,
		CMD_BANK_PORT  = 3'd2,
		CMD_PLANE_PORT = 3'd3,
		CMD_ATTR_PORT  = 3'd4,
		CMD_CTRL_PORT  = 3'd5,
		CMD_LOAD_BOOT  = 3'd6,
		CMD_LOAD_SEC   = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		SEL_ZERO   = 3'd0,
		SEL_RAM    = 3'd1,
		SEL_BOOT   = 3'd2,
		SEL_SEC    = 3'd3,
		SEL_OPEN   = 3'd4,
		SEL_PAL    = 3'd5,
		SEL_PLANES = 3'd6
	} sel_t;

	localparam logic [1:0] WIN_VIDEO = 2'd2;
	localparam logic [3:0] BANK_BOOT = 4'b1000;
	localparam logic [7:0] OPEN_BUS  = 8'hff;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] address;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       attr_strobe;
		logic [3:0] attr_value;
		logic       io_strobe;
		logic       mio_flag;
		logic [1:0] port_c_low;
	} result_t;

	// classified operation passed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic [1:0]  win;
		logic [13:0] off;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        boot_ok;
		logic        sec_ok;
	} op_t;

endpackage
`default_nettype wire

### src/banked_memory_with_vram_planes_core.sv
`default_nettype none
// Banked 64K memory controller with planar video RAM.
// Input channel: present an item on item and raise push; it transfers at a
// rising edge with push high and full low. Commands cover CPU reads and
// writes, the bank, plane, attribute and control ports, and ROM loads.
// Result channel: while empty is low the oldest result is on result; it
// transfers at a rising edge with pop high. Every item yields one result.
// The path from input transfer to result shown runs through the queue
// write at the transfer edge, then the registered memory read, then the
// result register. One item is in the back end at a time, so the back
// end takes no new item until the last one has moved into the result
// register, and a stalled result register holds the back end as well.
// A two-entry queue between front and back lets the input side keep
// taking items while a result waits; when the receiver stalls, hold the
// result and stall the back end, and full rises once the queue fills.
// Reset: asynchronous arst_n resets the port registers and starts a
// clearing pass through all 65536 RAM addresses and through ROMs and
// planes; full stays high until it ends.
module banked_memory_with_vram_planes_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  bmv_pkg::item_t   item,
	output logic             empty,
	input  wire logic        pop,
	output bmv_pkg::result_t result
);

	logic         op_valid;
	logic         op_take;
	logic         clearing;
	bmv_pkg::op_t op;

	// front: classify and queue each transfer
	bmv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.hold_off (clearing),
		.full     (full),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	// back: memories, port state and result register
	bmv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
`default_nettype wire

### src/bmv_front.sv
`default_nettype none
module bmv_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  bmv_pkg::item_t     item,
	input  wire logic          hold_off,
	output logic               full,
	output logic               op_valid,
	output bmv_pkg::op_t       op,
	input  wire logic          op_take
);

	bmv_pkg::op_t fifo_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;
	bmv_pkg::op_t op_new;

	// classify: split window and offset, range-check ROM loads
	always_comb begin
		op_new.cmd     = bmv_pkg::cmd_t'(item.command);
		op_new.win     = item.address[15:14];
		op_new.off     = item.address[13:0];
		op_new.addr    = item.address;
		op_new.data    = item.data;
		op_new.boot_ok = (item.address[15:14] == 2'd0);
		op_new.sec_ok  = !item.address[15];
	end

	assign full     = (count_q == 2'd2) || hold_off;
	assign do_push  = push && !full;
	assign do_pop   = op_take && (count_q != 2'd0);
	assign op_valid = (count_q != 2'd0);
	assign op       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

### src/bmv_back.sv
`default_nettype none
module bmv_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	input  bmv_pkg::op_t       op,
	output logic               op_take,
	output logic               clearing,
	output logic               empty,
	input  wire logic          pop,
	output bmv_pkg::result_t   result
);

	logic [7:0] main_ram [65536];
	logic [7:0] boot_rom [16384];
	logic [7:0] sec_rom  [32768];
	logic [7:0] plane0   [16384];
	logic [7:0] plane1   [16384];
	logic [7:0] plane2   [16384];
	logic [3:0] attr_mem [16384];
	logic [3:0] palette_q [16];

	logic [3:0] bank_mode_q;
	logic [7:0] plane_ctl_q;
	logic [3:0] attr_input_q;
	logic [3:0] attr_hold_q;
	logic       video_en_q;
	logic       pal_en_q;
	logic       attr_keep_q;

	logic [15:0] clr_cnt_q;
	logic        clr_q;

	logic [7:0] ram_rd_q, boot_rd_q, sec_rd_q, p0_rd_q, p1_rd_q, p2_rd_q;
	logic [3:0] attr_rd_q;

	logic             s1_valid_q;
	bmv_pkg::sel_t    sel_s1;
	logic [2:0]       pmask_s1;
	logic [3:0]       pal_s1;
	logic             strobe_s1;
	logic             strobe_rd_s1;
	logic [3:0]       hold_s1;
	logic             io_s1;
	logic [3:0]       bank_d_s1;

	bmv_pkg::result_t out_q;
	logic             out_valid_q;

	logic             start;
	logic             s1_done;
	logic             vid, pal, mem_rd, mem_wr;
	bmv_pkg::sel_t    sel;
	logic [14:0]      sec_addr;
	logic             ram_we, p0_we, p1_we, p2_we, at_we, boot_we, sec_we;
	logic [3:0]       new_hold;
	logic [7:0]       planes_and;
	bmv_pkg::result_t res;

	assign clearing = clr_q;
	assign s1_done  = s1_valid_q && (!out_valid_q || pop);
	assign start    = op_valid && !s1_valid_q && !clr_q;
	assign op_take  = start;

	always_comb begin
		mem_rd   = (op.cmd == bmv_pkg::CMD_MEM_READ);
		mem_wr   = (op.cmd == bmv_pkg::CMD_MEM_WRITE);
		vid      = video_en_q && (op.win == bmv_pkg::WIN_VIDEO);
		pal      = pal_en_q && (plane_ctl_q[6:4] == 3'd0);
		sec_addr = {1'b0, op.off};
		sel      = bmv_pkg::SEL_ZERO;
		if (mem_rd) begin
			priority if (vid) begin
				sel = pal ? bmv_pkg::SEL_PAL : bmv_pkg::SEL_PLANES;
			end else if (bank_mode_q[3]) begin
				sel = bmv_pkg::SEL_BOOT;
			end else begin
				unique case (op.win)
					2'd0: sel = bank_mode_q[1] ? bmv_pkg::SEL_RAM : bmv_pkg::SEL_SEC;
					2'd1: begin
						sec_addr = {1'b1, op.off};
						priority if (bank_mode_q[0]) sel = bmv_pkg::SEL_BOOT;
						else if (bank_mode_q[1]) sel = bmv_pkg::SEL_RAM;
						else sel = bmv_pkg::SEL_SEC;
					end
					2'd2: sel = bank_mode_q[2] ? bmv_pkg::SEL_OPEN : bmv_pkg::SEL_RAM;
					default: sel = bmv_pkg::SEL_RAM;
				endcase
			end
		end
		ram_we  = start && mem_wr && !vid && !bank_mode_q[3] &&
			!((op.win == bmv_pkg::WIN_VIDEO) && bank_mode_q[2]);
		p0_we   = start && mem_wr && vid && !pal && plane_ctl_q[4];
		p1_we   = start && mem_wr && vid && !pal && plane_ctl_q[5];
		p2_we   = start && mem_wr && vid && !pal && plane_ctl_q[6];
		at_we   = p2_we;
		boot_we = start && (op.cmd == bmv_pkg::CMD_LOAD_BOOT) && op.boot_ok;
		sec_we  = start && (op.cmd == bmv_pkg::CMD_LOAD_SEC) && op.sec_ok;
		new_hold = attr_keep_q ? attr_hold_q : attr_input_q;
	end

	// memories: clearing pass owns the write ports after reset
	always_ff @(posedge clk) begin
		if (clr_q) begin
			main_ram[clr_cnt_q]        <= 8'h00;
			boot_rom[clr_cnt_q[13:0]]  <= bmv_pkg::OPEN_BUS;
			sec_rom[clr_cnt_q[14:0]]   <= bmv_pkg::OPEN_BUS;
			plane0[clr_cnt_q[13:0]]    <= 8'h00;
			plane1[clr_cnt_q[13:0]]    <= 8'h00;
			plane2[clr_cnt_q[13:0]]    <= 8'h00;
			attr_mem[clr_cnt_q[13:0]]  <= 4'h0;
		end else begin
			if (ram_we) main_ram[op.addr] <= op.data;
			if (boot_we) boot_rom[op.addr[13:0]] <= op.data;
			if (sec_we) sec_rom[op.addr[14:0]] <= op.data;
			if (p0_we) plane0[op.off] <= plane_ctl_q[0] ? op.data : bmv_pkg::OPEN_BUS;
			if (p1_we) plane1[op.off] <= plane_ctl_q[1] ? op.data : bmv_pkg::OPEN_BUS;
			if (p2_we) plane2[op.off] <= plane_ctl_q[2] ? op.data : bmv_pkg::OPEN_BUS;
			if (at_we) attr_mem[op.off] <= new_hold;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ram_rd_q  <= main_ram[op.addr];
			boot_rd_q <= boot_rom[op.off];
			sec_rd_q  <= sec_rom[sec_addr];
			p0_rd_q   <= plane0[op.off];
			p1_rd_q   <= plane1[op.off];
			p2_rd_q   <= plane2[op.off];
			attr_rd_q <= attr_mem[op.off];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sel_s1       <= sel;
			pmask_s1     <= plane_ctl_q[6:4] & plane_ctl_q[2:0];
			pal_s1       <= palette_q[op.addr[3:0]];
			strobe_s1    <= p2_we || (mem_rd && vid && !pal && plane_ctl_q[6] &&
				plane_ctl_q[2]);
			strobe_rd_s1 <= mem_rd;
			hold_s1      <= new_hold;
			io_s1        <= (op.cmd == bmv_pkg::CMD_BANK_PORT);
			bank_d_s1    <= op.data[3:0];
		end
	end

	always_comb begin
		planes_and = bmv_pkg::OPEN_BUS;
		if (pmask_s1[0]) planes_and = planes_and & p0_rd_q;
		if (pmask_s1[1]) planes_and = planes_and & p1_rd_q;
		if (pmask_s1[2]) planes_and = planes_and & p2_rd_q;
		unique case (sel_s1)
			bmv_pkg::SEL_RAM:    res.read_data = ram_rd_q;
			bmv_pkg::SEL_BOOT:   res.read_data = boot_rd_q;
			bmv_pkg::SEL_SEC:    res.read_data = sec_rd_q;
			bmv_pkg::SEL_OPEN:   res.read_data = bmv_pkg::OPEN_BUS;
			bmv_pkg::SEL_PAL:    res.read_data = {4'h0, pal_s1};
			bmv_pkg::SEL_PLANES: res.read_data = planes_and;
			default:             res.read_data = 8'h00;
		endcase
		res.attr_strobe = strobe_s1;
		res.attr_value  = strobe_s1 ? (strobe_rd_s1 ? attr_rd_q : hold_s1) : 4'h0;
		res.io_strobe   = io_s1;
		res.mio_flag    = io_s1 && bank_d_s1[3];
		res.port_c_low  = io_s1 ? bank_d_s1[1:0] : 2'd0;
	end

	always_ff @(posedge clk) begin
		if (s1_done) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) palette_q[i] <= 4'h0;
		end else if (start && mem_wr && vid && pal) begin
			palette_q[op.addr[3:0]] <= op.data[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_mode_q  <= bmv_pkg::BANK_BOOT;
			plane_ctl_q  <= 8'h00;
			attr_input_q <= 4'h0;
			attr_hold_q  <= 4'h0;
			video_en_q   <= 1'b0;
			pal_en_q     <= 1'b0;
			attr_keep_q  <= 1'b0;
			clr_cnt_q    <= 16'd0;
			clr_q        <= 1'b1;
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 16'd1;
				if (clr_cnt_q == 16'hffff) clr_q <= 1'b0;
			end
			if (start) begin
				unique case (op.cmd)
					bmv_pkg::CMD_BANK_PORT: begin
						bank_mode_q <= {1'b0, op.data[2:0]};
						video_en_q  <= op.data[2];
					end
					bmv_pkg::CMD_PLANE_PORT: plane_ctl_q  <= op.data;
					bmv_pkg::CMD_ATTR_PORT:  attr_input_q <= op.data[3:0];
					bmv_pkg::CMD_CTRL_PORT: begin
						attr_keep_q <= op.data[4];
						pal_en_q    <= (op.data[3:2] != 2'd0);
					end
					default: begin
						if (p2_we) attr_hold_q <= new_hold;
					end
				endcase
			end
			// plane 2 read reloads the hold latch from the attribute plane
			if (s1_done && strobe_s1 && strobe_rd_s1) attr_hold_q <= attr_rd_q;
			priority if (start) s1_valid_q <= 1'b1;
			else if (s1_done) s1_valid_q <= 1'b0;
			priority if (s1_done) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	a_no_start_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !start) else $error("item started during clearing pass");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> s1_valid_q && !start) else $error("second item entered back end");
	a_strobe_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.io_strobe && out_q.attr_strobe))
		else $error("bank and attribute strobes together");
	a_done_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done |=> out_valid_q) else $error("finished item not presented");

endmodule
`default_nettype wire
